FILE: hw/rtl/sbf_pkg.sv
// shared types and constants for the spring / bungee force unit
// no dependencies; imported by every module of the block
package sbf_pkg;

    // configuration register width and port index width
    localparam int REG_W       = 32;
    localparam int CFG_ADDR_W  = 2;

    // default geometry
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // three vector components handled side by side
    localparam int LANES = 3;

    // register reset values
    localparam logic [REG_W-1:0] K_RESET   = REG_W'(65536);
    localparam logic [REG_W-1:0] LEN_RESET = REG_W'(65536);

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SPRING_CONSTANT = 2'd0,
        REG_REST_LENGTH     = 2'd1,
        REG_MODE            = 2'd2
    } sbf_reg_t;

    // pipeline control handed to every cell
    typedef struct packed {
        logic en;
        logic vld;
    } sbf_ctl_t;

endpackage

FILE: hw/rtl/sbf_sqrt_cell.sv
// one cell of the square root chain: settles one root bit per cell
// depends on sbf_pkg
module sbf_sqrt_cell #(
    parameter int RW     = 34,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbf_pkg::sbf_ctl_t     ctl,
    input  logic [2*RW-1:0]       rad_in,
    input  logic [RW-1:0]         root_in,
    input  logic [RW-1:0]         rem_in,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  vld_out,
    output logic [2*RW-1:0]       rad_out,
    output logic [RW-1:0]         root_out,
    output logic [RW-1:0]         rem_out,
    output logic [SIDE_W-1:0]     side_out
);
    import sbf_pkg::*;

    logic              vld_reg;
    logic [2*RW-1:0]   rad_reg, rad_next;
    logic [RW-1:0]     root_reg, root_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [SIDE_W-1:0] side_reg;
    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;
    logic [RW+1:0]     diff;
    logic              ge;

    // trial subtract of (4*root + 1) against the shifted remainder
    always_comb
    begin
        rem_sh    = {rem_in, rad_in[2*RW-1 -: 2]};
        trial     = {root_in, 2'b01};
        diff      = rem_sh - trial;
        ge        = (rem_sh >= trial);
        rem_next  = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
        root_next = {root_in[RW-2:0], ge};
        rad_next  = {rad_in[2*RW-3:0], 2'b00};
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            vld_reg <= ctl.vld;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rad_out  = rad_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;
    assign side_out = side_reg;

endmodule

FILE: hw/rtl/sbf_div_cell.sv
// one cell of the divider chain: one quotient bit per lane per cell
// depends on sbf_pkg
module sbf_div_cell #(
    parameter int RW     = 34,
    parameter int QW     = 32,
    parameter int SIDE_W = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sbf_pkg::sbf_ctl_t                     ctl,
    input  logic [RW-1:0]                         len_in,
    input  logic [sbf_pkg::LANES-1:0][RW-1:0]     rem_in,
    input  logic [sbf_pkg::LANES-1:0][QW-1:0]     nq_in,
    input  logic [SIDE_W-1:0]                     side_in,
    output logic                                  vld_out,
    output logic [RW-1:0]                         len_out,
    output logic [sbf_pkg::LANES-1:0][RW-1:0]     rem_out,
    output logic [sbf_pkg::LANES-1:0][QW-1:0]     nq_out,
    output logic [SIDE_W-1:0]                     side_out
);
    import sbf_pkg::*;

    logic                        vld_reg;
    logic [RW-1:0]               len_reg;
    logic [LANES-1:0][RW-1:0]    rem_reg, rem_next;
    logic [LANES-1:0][QW-1:0]    nq_reg, nq_next;
    logic [SIDE_W-1:0]           side_reg;
    logic [LANES-1:0][RW:0]      t;
    logic [LANES-1:0][RW:0]      diff;
    logic [LANES-1:0]            ge;

    // restoring step: numerator bits shift out the top, quotient bits in the bottom
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            t[l]        = {rem_in[l], nq_in[l][QW-1]};
            diff[l]     = t[l] - {1'b0, len_in};
            ge[l]       = (t[l] >= {1'b0, len_in});
            rem_next[l] = ge[l] ? diff[l][RW-1:0] : t[l][RW-1:0];
            nq_next[l]  = {nq_in[l][QW-2:0], ge[l]};
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            vld_reg <= ctl.vld;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            len_reg  <= len_in;
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign len_out  = len_reg;
    assign rem_out  = rem_reg;
    assign nq_out   = nq_reg;
    assign side_out = side_reg;

endmodule

FILE: hw/rtl/spring_bungee_force_top.sv
// spring / bungee force unit, top level: front stages, root chain, force stages,
// divider chain and output register; depends on sbf_pkg, sbf_sqrt_cell, sbf_div_cell
//
//  channel   dir  fields
//  s_axis    in   tdata: pos_x, pos_y, pos_z, end_x, end_y, end_z
//  m_axis    out  tdata: force_x, force_y, force_z; tuser: applied, saturated
//  cfg       in   cfg_addr 0 spring_constant, 1 rest_length, 2 mode
//
// one request accepted per cycle while m_axis is not stalled; the pipe holds COORD_WIDTH+2 root cells,
// COORD_WIDTH divider cells and eight single stages
// the root and divider chains set the latency, not the rate
// a stall on m_axis freezes the whole pipe; s_axis_tready drops with it
// reset clears valid flags and loads register defaults
module spring_bungee_force_top #(
    parameter int COORD_WIDTH = sbf_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = sbf_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pos_x, pos_y, pos_z, end_x, end_y, end_z from bit 0 up
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // force_x, force_y, force_z from bit 0 up
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // applied, saturated from bit 0 up
    output logic [1:0]                             m_axis_tuser,
    input  logic                                   cfg_we,
    input  logic [sbf_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [sbf_pkg::REG_W-1:0]              cfg_wdata
);
    import sbf_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int AW    = CW + 1;
    localparam int RW    = CW + 2;
    localparam int SW    = 2 * RW;
    localparam int EW    = ((RW > REG_W) ? RW : REG_W) + 1;
    localparam int PW    = REG_W + EW - 1;
    localparam int MW    = PW - FRAC_BITS;
    localparam int HW    = MW - CW;
    localparam int NW    = MW + AW;
    localparam int QW    = CW;
    localparam int OUT_W = ((3*CW+7)/8)*8;
    localparam int SQ_SIDE_W  = LANES*AW + 2*LANES;
    localparam int DIV_SIDE_W = 2*LANES + 1;

    // configuration registers
    logic [REG_W-1:0] k_reg;
    logic [REG_W-1:0] rest_reg;
    logic             mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= K_RESET;
            rest_reg <= LEN_RESET;
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (sbf_reg_t'(cfg_addr))
                REG_SPRING_CONSTANT: k_reg    <= cfg_wdata;
                REG_REST_LENGTH:     rest_reg <= cfg_wdata;
                REG_MODE:            mode_reg <= cfg_wdata[0];
                default:             ;
            endcase
        end
    end

    // pipeline advance
    logic en;
    logic out_vld_reg;
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage 0: displacement, magnitude and sign
    logic                     v0_reg;
    logic [LANES-1:0][AW-1:0] ad0_reg, ad0_next;
    logic [LANES-1:0]         sg0_reg, sg0_next;
    logic [LANES-1:0]         nz0_reg, nz0_next;
    logic [LANES-1:0][AW-1:0] d0;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            d0[i] = {s_axis_tdata[i*CW+CW-1], s_axis_tdata[i*CW +: CW]}
                  - {s_axis_tdata[(i+3)*CW+CW-1], s_axis_tdata[(i+3)*CW +: CW]};
            sg0_next[i] = d0[i][AW-1];
            nz0_next[i] = |d0[i];
            ad0_next[i] = d0[i][AW-1] ? (~d0[i] + AW'(1)) : d0[i];
        end
    end

    // stage 1: squares
    logic                       v1_reg;
    logic [LANES-1:0][2*AW-1:0] sq1_reg;
    logic [LANES-1:0][AW-1:0]   ad1_reg;
    logic [LANES-1:0]           sg1_reg, nz1_reg;

    // stage 2: sum of squares
    logic                     v2_reg;
    logic [SW-1:0]            sum2_reg;
    logic [LANES-1:0][AW-1:0] ad2_reg;
    logic [LANES-1:0]         sg2_reg, nz2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad0_reg <= ad0_next;
            sg0_reg <= sg0_next;
            nz0_reg <= nz0_next;
            for (int i = 0; i < LANES; i++)
            begin
                sq1_reg[i] <= ad0_reg[i] * ad0_reg[i];
            end
            ad1_reg  <= ad0_reg;
            sg1_reg  <= sg0_reg;
            nz1_reg  <= nz0_reg;
            sum2_reg <= SW'(sq1_reg[0]) + SW'(sq1_reg[1]) + SW'(sq1_reg[2]);
            ad2_reg  <= ad1_reg;
            sg2_reg  <= sg1_reg;
            nz2_reg  <= nz1_reg;
        end
    end

    // square root chain
    logic                 sq_vld  [0:RW];
    logic [SW-1:0]        sq_rad  [0:RW];
    logic [RW-1:0]        sq_root [0:RW];
    logic [RW-1:0]        sq_rem  [0:RW];
    logic [SQ_SIDE_W-1:0] sq_side [0:RW];
    sbf_ctl_t             sq_ctl  [0:RW-1];

    assign sq_vld[0]  = v2_reg;
    assign sq_rad[0]  = sum2_reg;
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;
    assign sq_side[0] = {nz2_reg, sg2_reg, ad2_reg};

    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        assign sq_ctl[g] = '{en: en, vld: sq_vld[g]};
        sbf_sqrt_cell #(
            .RW     (RW),
            .SIDE_W (SQ_SIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (sq_ctl[g]),
            .rad_in   (sq_rad[g]),
            .root_in  (sq_root[g]),
            .rem_in   (sq_rem[g]),
            .side_in  (sq_side[g]),
            .vld_out  (sq_vld[g+1]),
            .rad_out  (sq_rad[g+1]),
            .root_out (sq_root[g+1]),
            .rem_out  (sq_rem[g+1]),
            .side_out (sq_side[g+1])
        );
    end

    // extension stage: len - L, direction and activity
    logic [RW-1:0]            len_s;
    logic [LANES-1:0][AW-1:0] ad_s;
    logic [LANES-1:0]         sg_s, nz_s;
    logic [EW-1:0]            ext_s;
    logic [LANES-1:0]         neg_s;
    logic                     ext_pos_s, ext_neg_s, act_s;

    always_comb
    begin
        len_s = sq_root[RW];
        {nz_s, sg_s, ad_s} = sq_side[RW];
        ext_s     = EW'(len_s) - EW'(rest_reg);
        ext_pos_s = !ext_s[EW-1] && (|ext_s);
        ext_neg_s = ext_s[EW-1];
        act_s     = (|len_s) && !(mode_reg && !ext_pos_s);
        for (int i = 0; i < LANES; i++)
        begin
            neg_s[i] = (ext_pos_s && nz_s[i] && !sg_s[i]) || (ext_neg_s && sg_s[i]);
        end
    end

    logic                     ve_reg, vm_reg, vp1_reg, vp2_reg;
    logic [EW-2:0]            aext_reg;
    logic [RW-1:0]            len_e_reg, len_m_reg, len_p1_reg, len_p2_reg;
    logic [LANES-1:0][AW-1:0] ad_e_reg, ad_m_reg;
    logic [LANES-1:0]         neg_e_reg, neg_m_reg, neg_p1_reg, neg_p2_reg;
    logic                     act_e_reg, act_m_reg, act_p1_reg, act_p2_reg;
    logic [MW-1:0]            m_reg;
    logic [PW-1:0]            prod_m;
    logic [LANES-1:0][CW+AW-1:0] pl_reg;
    logic [LANES-1:0][HW+AW-1:0] ph_reg;
    logic [LANES-1:0][NW-1:0] n_reg;

    assign prod_m = k_reg * aext_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg  <= 1'b0;
            vm_reg  <= 1'b0;
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
        end
        else if (en)
        begin
            ve_reg  <= sq_vld[RW];
            vm_reg  <= ve_reg;
            vp1_reg <= vm_reg;
            vp2_reg <= vp1_reg;
        end
    end

    // magnitude k*|ext|, then split products against each |d|
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aext_reg  <= ext_s[EW-1] ? (~ext_s[EW-2:0] + (EW-1)'(1)) : ext_s[EW-2:0];
            len_e_reg <= len_s;
            ad_e_reg  <= ad_s;
            neg_e_reg <= neg_s;
            act_e_reg <= act_s;

            m_reg     <= prod_m[PW-1:FRAC_BITS];
            len_m_reg <= len_e_reg;
            ad_m_reg  <= ad_e_reg;
            neg_m_reg <= neg_e_reg;
            act_m_reg <= act_e_reg;

            for (int i = 0; i < LANES; i++)
            begin
                pl_reg[i] <= m_reg[CW-1:0] * ad_m_reg[i];
                ph_reg[i] <= m_reg[MW-1:CW] * ad_m_reg[i];
            end
            len_p1_reg <= len_m_reg;
            neg_p1_reg <= neg_m_reg;
            act_p1_reg <= act_m_reg;

            for (int i = 0; i < LANES; i++)
            begin
                n_reg[i] <= NW'(pl_reg[i]) + (NW'(ph_reg[i]) << CW);
            end
            len_p2_reg <= len_p1_reg;
            neg_p2_reg <= neg_p1_reg;
            act_p2_reg <= act_p1_reg;
        end
    end

    // quotient overflow check and divider entry
    logic [LANES-1:0]         ovf_s;
    logic [LANES-1:0][RW-1:0] rem0_s;
    logic [LANES-1:0][QW-1:0] nq0_s;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            ovf_s[i]  = (n_reg[i][NW-1:QW] >= (NW-QW)'(len_p2_reg));
            rem0_s[i] = n_reg[i][QW+RW-1:QW];
            nq0_s[i]  = n_reg[i][QW-1:0];
        end
    end

    // divider chain
    logic                      dv_vld  [0:QW];
    logic [RW-1:0]             dv_len  [0:QW];
    logic [LANES-1:0][RW-1:0]  dv_rem  [0:QW];
    logic [LANES-1:0][QW-1:0]  dv_nq   [0:QW];
    logic [DIV_SIDE_W-1:0]     dv_side [0:QW];
    sbf_ctl_t                  dv_ctl  [0:QW-1];

    assign dv_vld[0]  = vp2_reg;
    assign dv_len[0]  = len_p2_reg;
    assign dv_rem[0]  = rem0_s;
    assign dv_nq[0]   = nq0_s;
    assign dv_side[0] = {ovf_s, neg_p2_reg, act_p2_reg};

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        assign dv_ctl[g] = '{en: en, vld: dv_vld[g]};
        sbf_div_cell #(
            .RW     (RW),
            .QW     (QW),
            .SIDE_W (DIV_SIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (dv_ctl[g]),
            .len_in   (dv_len[g]),
            .rem_in   (dv_rem[g]),
            .nq_in    (dv_nq[g]),
            .side_in  (dv_side[g]),
            .vld_out  (dv_vld[g+1]),
            .len_out  (dv_len[g+1]),
            .rem_out  (dv_rem[g+1]),
            .nq_out   (dv_nq[g+1]),
            .side_out (dv_side[g+1])
        );
    end

    // sign and saturation
    logic [LANES-1:0]         ovf_f, neg_f, sat_f;
    logic                     act_f;
    logic [LANES-1:0][QW-1:0] q_f;
    logic [LANES-1:0][CW-1:0] frc_f;
    logic                     pos_sat, neg_sat;

    always_comb
    begin
        {ovf_f, neg_f, act_f} = dv_side[QW];
        q_f = dv_nq[QW];
        for (int i = 0; i < LANES; i++)
        begin
            pos_sat = ovf_f[i] || q_f[i][QW-1];
            neg_sat = ovf_f[i] || (q_f[i][QW-1] && (|q_f[i][QW-2:0]));
            if (!act_f)
            begin
                frc_f[i] = '0;
                sat_f[i] = 1'b0;
            end
            else if (neg_f[i])
            begin
                frc_f[i] = neg_sat ? {1'b1, {(CW-1){1'b0}}} : (~q_f[i] + CW'(1));
                sat_f[i] = neg_sat;
            end
            else
            begin
                frc_f[i] = pos_sat ? {1'b0, {(CW-1){1'b1}}} : q_f[i];
                sat_f[i] = pos_sat;
            end
        end
    end

    // output register
    logic [3*CW-1:0] frc_out_reg;
    logic            app_out_reg, sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frc_out_reg <= frc_f;
            app_out_reg <= act_f;
            sat_out_reg <= |sat_f;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_W'(frc_out_reg);
    assign m_axis_tuser  = {sat_out_reg, app_out_reg};

`ifndef NO_ASSERTIONS
    // a request taken at the input shows up valid in the first stage
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v0_reg)
        else $error("accepted request lost at first stage");

    // a force that is not applied is all zero
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
        else $error("nonzero force without applied flag");

    // clipping only happens on an applied force
    a_sat_app: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("saturated flag without applied flag");
`endif

endmodule
